[hw/rtl/binary_to_balanced_ternary_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the balanced ternary converter
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_BALANCED_TERNARY_ASSERT_SVH
`define BINARY_TO_BALANCED_TERNARY_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BBT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/bbt_pkg.sv]
// ----------------------------------------------------------------------------
// bbt_pkg
// Types and constants shared by the balanced ternary converter.
// ----------------------------------------------------------------------------
`default_nettype none

package bbt_pkg;

   localparam int VALUE_W = 32;
   localparam int TRIT_W  = 2;

   // digit codes
   localparam logic [TRIT_W-1:0] TRIT_ZERO  = 2'd0;
   localparam logic [TRIT_W-1:0] TRIT_PLUS  = 2'd1;
   localparam logic [TRIT_W-1:0] TRIT_MINUS = 2'd2;

   // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for any 32-bit x
   localparam logic [VALUE_W-1:0] RECIP3       = 32'hAAAA_AAAB;
   localparam int                 RECIP3_SHIFT = 33;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [TRIT_W-1:0]  trit_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture a new request
      logic step;   // form one digit
      logic issue;  // read one digit for the response
   } bbt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic conv_done;  // digit formed this cycle is the last one
      logic idx_zero;   // read pointer is at the least significant digit
   } bbt_status_type;

   // remainder of (mag + 1) / 3 mapped to a digit code, sign applied
   function automatic trit_type trit_code(input logic [1:0] rem, input logic neg);
      trit_type code;
      case (rem)
         2'd0:    code = neg ? TRIT_PLUS : TRIT_MINUS;
         2'd2:    code = neg ? TRIT_MINUS : TRIT_PLUS;
         default: code = TRIT_ZERO;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/bbt_if.sv]
// ----------------------------------------------------------------------------
// bbt_req_if / bbt_rsp_if
// Valid/ready channels for requests and digit responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbt_req_if;
   import bbt_pkg::*;
   logic      valid;
   logic      ready;
   value_type value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface bbt_rsp_if;
   import bbt_pkg::*;
   logic     valid;
   logic     ready;
   trit_type trit;
   logic     last_digit;
   modport source (output valid, output trit, output last_digit, input ready);
   modport sink   (input valid, input trit, input last_digit, output ready);
endinterface

`default_nettype wire

[hw/rtl/bbt_ram.sv]
// ----------------------------------------------------------------------------
// bbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbt_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 21
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/bbt_datapath.sv]
// ----------------------------------------------------------------------------
// bbt_datapath
// Divide-by-3 digit former, digit buffer and response read pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module bbt_datapath #(
   parameter int MAX_TRITS = 21
) (
   input  wire logic                    clock,
   input  wire bbt_pkg::bbt_cmd_type    cmd,
   output bbt_pkg::bbt_status_type      status,
   input  wire bbt_pkg::value_type      req_value,
   output bbt_pkg::trit_type            rsp_trit,
   output logic                         rsp_last_digit
);
   import bbt_pkg::*;

   localparam int IDX_W = $clog2(MAX_TRITS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TRITS - 1);

   value_type        mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             last_ff, last_in;

   value_type              inc;
   logic [2*VALUE_W-1:0]   prod;
   value_type              quot;
   logic [1:0]             quot3_lo;
   logic [1:0]             rem;
   trit_type               code;
   value_type              abs_value;

   // one balanced digit: q = floor((mag + 1) / 3), digit = (mag + 1) mod 3 - 1
   always_comb begin
      inc      = mag_ff + VALUE_W'(1);
      prod     = (2*VALUE_W)'(inc) * (2*VALUE_W)'(RECIP3);
      quot     = VALUE_W'(prod >> RECIP3_SHIFT);
      quot3_lo = quot[1:0] + {quot[0], 1'b0};
      rem      = inc[1:0] - quot3_lo;
      code     = trit_code(rem, neg_ff);
   end

   assign abs_value = req_value[VALUE_W-1] ? (~req_value + VALUE_W'(1)) : req_value;

   // status back to the controller
   always_comb begin
      status.conv_done = (quot == '0) || (idx_ff == LAST_IDX);
      status.idx_zero  = (idx_ff == '0);
   end

   // next-state of the datapath registers
   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      idx_in  = idx_ff;
      last_in = last_ff;
      if (cmd.load) begin
         mag_in = abs_value;
         neg_in = req_value[VALUE_W-1];
         idx_in = '0;
      end else if (cmd.step) begin
         mag_in = quot;
         if (!status.conv_done) begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end else if (cmd.issue) begin
         last_in = status.idx_zero;
         if (!status.idx_zero) begin
            idx_in = idx_ff - IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
   end

   // digit buffer, least significant first
   bbt_ram #(
      .WIDTH (TRIT_W),
      .DEPTH (MAX_TRITS)
   ) u_digits (
      .clock   (clock),
      .wr_en   (cmd.step),
      .wr_addr (idx_ff),
      .wr_data (code),
      .rd_en   (cmd.issue),
      .rd_addr (idx_ff),
      .rd_data (rsp_trit)
   );

   assign rsp_last_digit = last_ff;

endmodule

`default_nettype wire

[hw/rtl/bbt_ctrl.sv]
// ----------------------------------------------------------------------------
// bbt_ctrl
// Sequencer: accept, form digits, stream them out most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_to_balanced_ternary_assert.svh"

module bbt_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output bbt_pkg::bbt_cmd_type         cmd,
   input  wire bbt_pkg::bbt_status_type status
);
   import bbt_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CONV  = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   // commands
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      cmd.load  = req_valid && (state_ff == ST_IDLE);
      cmd.step  = (state_ff == ST_CONV);
      cmd.issue = (state_ff == ST_EMIT) && (!valid_ff || rsp_ready);
   end

   // state transitions
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (status.conv_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cmd.issue && status.idx_zero) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid follows the buffer read data
   always_comb begin
      if (cmd.issue) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

   // checks
   `BBT_ASSERT_NOW(a_valid_in_emit, clock, reset, valid_ff,
      (state_ff == ST_EMIT) || (state_ff == ST_DRAIN), "response valid outside emit")
   `BBT_ASSERT_NEXT(a_conv_to_emit, clock, reset, cmd.step && status.conv_done,
      state_ff == ST_EMIT, "conversion end did not start emit")
   `BBT_ASSERT_NEXT(a_drain_done, clock, reset, (state_ff == ST_DRAIN) && rsp_ready,
      (state_ff == ST_IDLE) && !valid_ff, "last digit taken but not idle")

endmodule

`default_nettype wire

[hw/rtl/binary_to_balanced_ternary.sv]
// ----------------------------------------------------------------------------
// binary_to_balanced_ternary
// Converts a signed 32-bit integer into balanced ternary digits, most
// significant first, one response per digit, last_digit on the final one.
// ----------------------------------------------------------------------------
// channel   dir  payload                      width
// req_ch    in   value (signed)               32
// rsp_ch    out  trit (0, 1 = +1, 2 = -1)     2
//                last_digit                   1
//
// one request forms its n digits (one divide-by-3 multiply per digit), then
// streams them from the digit buffer, one per cycle while rsp_ch is ready
// zero gives a single 0 digit; only the MAX_TRITS low digits are kept
// reset is synchronous and needs no clearing pass; the buffer is written
// before it is read
// a stalled response holds its digit; the next request is taken once the
// last digit is delivered
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_balanced_ternary #(
   parameter int MAX_TRITS = 21
) (
   input wire logic  clock,
   input wire logic  reset,
   bbt_req_if.sink   req_ch,
   bbt_rsp_if.source rsp_ch
);
   import bbt_pkg::*;

   bbt_cmd_type    cmd;
   bbt_status_type status;

   // sequencer
   bbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // digit former and buffer
   bbt_datapath #(
      .MAX_TRITS (MAX_TRITS)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_ch.value),
      .rsp_trit       (rsp_ch.trit),
      .rsp_last_digit (rsp_ch.last_digit)
   );

endmodule

`default_nettype wire

[tb/binary_to_balanced_ternary_checker.sv]
// ----------------------------------------------------------------------------
// binary_to_balanced_ternary_checker
// Watches the request and digit channels of the converter. Each accepted
// request is converted here into its expected balanced ternary digits, most
// significant first; each accepted digit is compared against the oldest one
// still owed. Mismatches and unexpected digits are counted for the top.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_balanced_ternary_checker #(
   parameter int MAX_DIGITS = 21
) (
   input wire logic clock,
   input wire logic reset,
   bbt_req_if       req_mon,
   bbt_rsp_if       rsp_mon,
   output int       mismatches,
   output int       awaiting,
   output int       requests_seen,
   output int       digits_seen
);
   import bbt_pkg::*;

   typedef struct packed {
      trit_type trit;
      logic     last_digit;
   } digit_rsp_type;

   digit_rsp_type owed_digits [$];
   digit_rsp_type oldest;

   // balanced ternary expansion of one request, pushed most significant first
   function automatic void convert_to_trits(input value_type v);
      logic          neg;
      logic [63:0]   mag;
      logic [63:0]   rem;
      trit_type      code;
      trit_type      digits [MAX_DIGITS];
      int            n;
      int            k;
      digit_rsp_type d;
      neg = v[VALUE_W-1];
      mag = neg ? {32'd0, (~v + 32'd1)} : {32'd0, v};
      n = 0;
      // divide by three; a remainder of two becomes -1 with a carry
      while (mag != 64'd0 && n < MAX_DIGITS) begin
         rem = mag % 64'd3;
         mag = mag / 64'd3;
         if (rem == 64'd2) begin
            code = TRIT_MINUS;
            mag  = mag + 64'd1;
         end else if (rem == 64'd1) begin
            code = TRIT_PLUS;
         end else begin
            code = TRIT_ZERO;
         end
         // negative input mirrors the nonzero digits
         if (neg && code == TRIT_PLUS)
            code = TRIT_MINUS;
         else if (neg && code == TRIT_MINUS)
            code = TRIT_PLUS;
         digits[n] = code;
         n++;
      end
      // zero answers with a lone zero digit
      if (n == 0) begin
         d.trit       = TRIT_ZERO;
         d.last_digit = 1'b1;
         owed_digits.push_back(d);
      end else begin
         for (k = n - 1; k >= 0; k--) begin
            d.trit       = digits[k];
            d.last_digit = (k == 0);
            owed_digits.push_back(d);
         end
      end
   endfunction

   initial begin
      mismatches    = 0;
      requests_seen = 0;
      digits_seen   = 0;
      awaiting      = 0;
   end

   // predict on each request, compare on each digit
   always @(posedge clock) begin
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            convert_to_trits(req_mon.value);
            requests_seen++;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            digits_seen++;
            if (owed_digits.size() == 0) begin
               $error("digit with no request pending: trit %0d last_digit %0d",
                      rsp_mon.trit, rsp_mon.last_digit);
               mismatches++;
            end else begin
               oldest = owed_digits.pop_front();
               if (rsp_mon.trit !== oldest.trit) begin
                  $error("trit: expected %0d, actual %0d", oldest.trit, rsp_mon.trit);
                  mismatches++;
               end
               if (rsp_mon.last_digit !== oldest.last_digit) begin
                  $error("last_digit: expected %0d, actual %0d",
                         oldest.last_digit, rsp_mon.last_digit);
                  mismatches++;
               end
            end
         end
      end
      awaiting <= owed_digits.size();
   end

endmodule

`default_nettype wire

[tb/binary_to_balanced_ternary_test.sv]
// ----------------------------------------------------------------------------
// binary_to_balanced_ternary_test
// Drives signed integers into the converter, first corner values (zero,
// small magnitudes, range ends, the most negative value, the 20 and 21 digit
// boundary) and then random values, with random idle bursts on the request
// side and random stalls on the digit side. A checker beside the block
// predicts and compares every digit; this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_balanced_ternary_test;
   import bbt_pkg::*;

   localparam int DIGIT_LIMIT  = 21;
   localparam int CORNER_COUNT = 22;
   localparam int RANDOM_COUNT = 128;
   localparam int QUIET_TAIL   = 30;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   source_idles = 1'b1;
   bit   sink_idles   = 1'b1;
   int   mismatches;
   int   awaiting;
   int   requests_seen;
   int   digits_seen;
   int   i;

   value_type corner_values [CORNER_COUNT] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd2, -32'sd2, 32'sd3, -32'sd3, 32'sd4, -32'sd4,
      32'sd13, -32'sd13, 32'sd121, 32'sd122,
      32'sd1743392200, 32'sd1743392201, -32'sd1743392201,
      32'sd2147483647, -32'sd2147483647, 32'h8000_0000,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF
   };

   bbt_req_if req_ch ();
   bbt_rsp_if rsp_ch ();

   binary_to_balanced_ternary #(
      .MAX_TRITS (DIGIT_LIMIT)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   binary_to_balanced_ternary_checker #(
      .MAX_DIGITS (DIGIT_LIMIT)
   ) digit_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .mismatches    (mismatches),
      .awaiting      (awaiting),
      .requests_seen (requests_seen),
      .digits_seen   (digits_seen)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // overall time limit
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   // digit side: ready with random stall bursts
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (sink_idles && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // mix of full range, small, near powers of three and shortened values
   function automatic value_type random_value();
      longint    p;
      value_type v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 60) - 30;
         2: begin
            p = 1;
            repeat ($urandom_range(0, 20)) p = p * 3;
            p = p + $urandom_range(0, 2) - 1;
            v = p[31:0];
            if ($urandom_range(0, 1) == 1)
               v = ~v + 32'd1;
         end
         default: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1)
               v = ~v + 32'd1;
         end
      endcase
      return v;
   endfunction

   // one request, with an optional idle burst ahead of it
   task automatic send_request(input value_type v);
      if (source_idles && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // hold off until every owed digit has arrived
   task automatic wait_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   // reset, corner values, random values, verdict
   initial begin
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < CORNER_COUNT; i++)
         send_request(corner_values[i]);
      wait_until_drained();

      for (i = 0; i < RANDOM_COUNT; i++) begin
         // idling switched per stretch, none at the tail
         if (i % 25 == 0) begin
            source_idles = ($urandom_range(0, 2) != 0);
            sink_idles   = ($urandom_range(0, 2) != 0);
         end
         if (i >= RANDOM_COUNT - QUIET_TAIL) begin
            source_idles = 1'b0;
            sink_idles   = 1'b0;
         end
         if (i == 60)
            wait_until_drained();
         send_request(random_value());
      end
      wait_until_drained();
      repeat (50) @(posedge clock);

      $display("covered %0d requests and %0d digits: zero, range ends, most negative value,",
               requests_seen, digits_seen);
      $display("digit count boundaries and random values with stalls on both channels");
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
